// ===== rtl/spq_pkg.sv =====
`timescale 1ns / 1ps

package spq_pkg;

	// Fixed field widths
	localparam int KIND_W = 3;
	localparam int STAT_W = 3;
	localparam int POS_W  = 6;

	// Operation codes carried in the kind field
	typedef enum logic [KIND_W-1:0] {
		K_INSERT   = 3'd0,
		K_BEFORE   = 3'd1,
		K_AFTER    = 3'd2,
		K_REMOVE   = 3'd3,
		K_POP      = 3'd4,
		K_GET      = 3'd5,
		K_CONTAINS = 3'd6,
		K_CLEAR    = 3'd7
	} kind_t;

	// Result status codes
	localparam logic [STAT_W-1:0] STAT_OK       = 3'd0;
	localparam logic [STAT_W-1:0] STAT_NULL     = 3'd1;
	localparam logic [STAT_W-1:0] STAT_NOTFOUND = 3'd2;
	localparam logic [STAT_W-1:0] STAT_EMPTY    = 3'd3;
	localparam logic [STAT_W-1:0] STAT_FULL     = 3'd4;
	localparam logic [STAT_W-1:0] STAT_RANGE    = 3'd5;

	// Sequencer states
	typedef enum logic [3:0] {
		S_IDLE,
		S_DISPATCH,
		S_FIND_RD,
		S_FIND_CMP,
		S_UP_CHK,
		S_UP_CMP,
		S_READ_RD,
		S_READ_CAP,
		S_DN_CHK,
		S_DN_MOV,
		S_RESULT
	} state_t;

endpackage

// ===== rtl/spq_in_if.sv =====
`timescale 1ns / 1ps

interface spq_in_if #(
	parameter int HANDLE_BITS = 16,
	parameter int KEY_BITS    = 32
);
	logic                       valid;
	logic                       ready;
	logic [spq_pkg::KIND_W-1:0] kind;
	logic [HANDLE_BITS-1:0]     handle;
	logic [KEY_BITS-1:0]        key;
	logic [HANDLE_BITS-1:0]     ref_handle;
	logic [spq_pkg::POS_W-1:0]  position;

	modport source (output valid, kind, handle, key, ref_handle, position, input ready);
	modport sink (input valid, kind, handle, key, ref_handle, position, output ready);
endinterface

// ===== rtl/spq_out_if.sv =====
`timescale 1ns / 1ps

interface spq_out_if #(
	parameter int HANDLE_BITS = 16,
	parameter int KEY_BITS    = 32,
	parameter int LEN_BITS    = 7
);
	logic                       valid;
	logic                       ready;
	logic [spq_pkg::STAT_W-1:0] status;
	logic [HANDLE_BITS-1:0]     out_handle;
	logic [KEY_BITS-1:0]        out_key;
	logic                       found;
	logic [LEN_BITS-1:0]        length;

	modport source (output valid, status, out_handle, out_key, found, length, input ready);
	modport sink (input valid, status, out_handle, out_key, found, length, output ready);
endinterface

// ===== rtl/stable_priority_queue.sv =====
`timescale 1ns / 1ps

// Bounded ordered queue of handle/key entries held front to back in one RAM.
// in_ch carries one operation per beat (insert, insert before/after, remove,
// pop, get, contains, clear); out_ch returns exactly one result beat for each.
// cfg_we/cfg_wdata set ordered_mode (sorted insert when 1, tail append when 0);
// write it only while no operation is in flight.
// Clear and operations refused at dispatch finish without any RAM access;
// get reads one entry; searches walk the queue from the front; pop and
// remove shift the entries behind the removed one forward; inserts shift
// entries back from the tail until the new entry's slot is reached.
// Each entry visited passes through a RAM read state and then a
// compare/write state.
// One operation is in flight at a time; in_ch.ready is high while the
// sequencer is idle, also while a finished result still waits on out_ch.
// If out_ch stalls with a result pending, the next result is held inside
// until the pending beat is taken. Reset empties the queue, clears
// ordered_mode and drops any pending result; RAM contents are not cleared.
module stable_priority_queue #(
	parameter int DEPTH       = 64,
	parameter int KEY_BITS    = 32,
	parameter int HANDLE_BITS = 16
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      cfg_we,
	input  logic      cfg_wdata,
	spq_in_if.sink    in_ch,
	spq_out_if.source out_ch
);
	import spq_pkg::*;

	localparam int AW    = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;
	localparam int EW    = HANDLE_BITS + KEY_BITS;

	// Entry store
	logic [EW-1:0] mem [DEPTH];
	logic [EW-1:0] rd_q;
	logic [AW-1:0] rd_addr;
	logic          wr_en;
	logic [AW-1:0] wr_addr;
	logic [EW-1:0] wr_data;

	state_t state_q, state_d;

	logic                   ordered_q;
	kind_t                  kind_q;
	logic [HANDLE_BITS-1:0] h_q;
	logic [KEY_BITS-1:0]    k_q;
	logic [HANDLE_BITS-1:0] rh_q;
	logic [POS_W-1:0]       pos_q;
	logic                   sort_q;
	logic [CNT_W-1:0]       cnt_q;
	logic [CNT_W-1:0]       idx_q;
	logic [CNT_W-1:0]       tgt_q;

	logic [STAT_W-1:0]      rs_status_q;
	logic [HANDLE_BITS-1:0] rs_handle_q;
	logic [KEY_BITS-1:0]    rs_key_q;
	logic                   rs_found_q;

	logic                   o_valid_q;
	logic [STAT_W-1:0]      o_status_q;
	logic [HANDLE_BITS-1:0] o_handle_q;
	logic [KEY_BITS-1:0]    o_key_q;
	logic                   o_found_q;
	logic [CNT_W-1:0]       o_len_q;

	logic                   in_acc;
	logic                   deliver;
	logic [HANDLE_BITS-1:0] rd_hdl;
	logic [KEY_BITS-1:0]    rd_key;
	logic [HANDLE_BITS-1:0] srch;
	logic                   hit;
	logic                   at_end;
	logic                   full;
	logic                   pos_bad;
	logic                   stop_here;
	logic [CNT_W-1:0]       idx_inc;

	// Shared compare unit and decoded conditions
	assign rd_hdl    = rd_q[EW-1:KEY_BITS];
	assign rd_key    = rd_q[KEY_BITS-1:0];
	assign srch      = (kind_q == K_BEFORE || kind_q == K_AFTER) ? rh_q : h_q;
	assign hit       = (rd_hdl == srch);
	assign at_end    = (idx_q == cnt_q);
	assign full      = (cnt_q == CNT_W'(DEPTH));
	assign pos_bad   = (CMP_W'(pos_q) >= CMP_W'(cnt_q));
	assign stop_here = sort_q && !(k_q < rd_key);
	assign idx_inc   = idx_q + 1'b1;
	assign in_acc    = in_ch.valid && in_ch.ready;
	assign deliver   = (state_q == S_RESULT) && (!o_valid_q || out_ch.ready);

	// Configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ordered_q <= 1'b0;
		end else if (cfg_we) begin
			ordered_q <= cfg_wdata;
		end
	end

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_acc) state_d = S_DISPATCH;
			end
			S_DISPATCH: begin
				case (kind_q)
					K_INSERT:
						state_d = (h_q == '0 || full) ? S_RESULT : S_UP_CHK;
					K_BEFORE, K_AFTER:
						state_d = (h_q == '0 || rh_q == '0) ? S_RESULT : S_FIND_RD;
					K_REMOVE, K_CONTAINS:
						state_d = (h_q == '0) ? S_RESULT : S_FIND_RD;
					K_POP:
						state_d = (cnt_q == '0) ? S_RESULT : S_READ_RD;
					K_GET:
						state_d = pos_bad ? S_RESULT : S_READ_RD;
					default:
						state_d = S_RESULT;
				endcase
			end
			S_FIND_RD: begin
				state_d = at_end ? S_RESULT : S_FIND_CMP;
			end
			S_FIND_CMP: begin
				if (!hit) begin
					state_d = S_FIND_RD;
				end else begin
					case (kind_q)
						K_REMOVE:          state_d = S_DN_CHK;
						K_BEFORE, K_AFTER: state_d = full ? S_RESULT : S_UP_CHK;
						default:           state_d = S_RESULT;
					endcase
				end
			end
			S_UP_CHK: begin
				state_d = (idx_q == tgt_q) ? S_RESULT : S_UP_CMP;
			end
			S_UP_CMP: begin
				state_d = stop_here ? S_RESULT : S_UP_CHK;
			end
			S_READ_RD: begin
				state_d = S_READ_CAP;
			end
			S_READ_CAP: begin
				state_d = (kind_q == K_POP) ? S_DN_CHK : S_RESULT;
			end
			S_DN_CHK: begin
				state_d = (idx_inc == cnt_q) ? S_RESULT : S_DN_MOV;
			end
			S_DN_MOV: begin
				state_d = S_DN_CHK;
			end
			S_RESULT: begin
				if (deliver) state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// Handshake, RAM address and write controls
	always_comb begin
		in_ch.ready = (state_q == S_IDLE);
		wr_en       = 1'b0;
		wr_addr     = AW'(idx_q);
		wr_data     = rd_q;
		rd_addr     = AW'(idx_q);
		case (state_q)
			S_UP_CHK: begin
				rd_addr = AW'(idx_q - 1'b1);
				if (idx_q == tgt_q) begin
					wr_en   = 1'b1;
					wr_data = {h_q, k_q};
				end
			end
			S_UP_CMP: begin
				wr_en = 1'b1;
				if (stop_here) wr_data = {h_q, k_q};
			end
			S_READ_RD: begin
				rd_addr = (kind_q == K_POP) ? '0 : AW'(pos_q);
			end
			S_DN_CHK: begin
				rd_addr = AW'(idx_inc);
			end
			S_DN_MOV: begin
				wr_en = 1'b1;
			end
			default: begin
			end
		endcase
	end

	// Entry RAM: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (wr_en) mem[wr_addr] <= wr_data;
	end

	always_ff @(posedge clk) begin
		rd_q <= mem[rd_addr];
	end

	// Sequencer state and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			case (state_q)
				S_DISPATCH: begin
					if (kind_q == K_CLEAR) cnt_q <= '0;
				end
				S_UP_CHK: begin
					if (idx_q == tgt_q) cnt_q <= cnt_q + 1'b1;
				end
				S_UP_CMP: begin
					if (stop_here) cnt_q <= cnt_q + 1'b1;
				end
				S_DN_CHK: begin
					if (idx_inc == cnt_q) cnt_q <= cnt_q - 1'b1;
				end
				default: begin
				end
			endcase
		end
	end

	// Operation datapath
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (in_acc) begin
					kind_q      <= kind_t'(in_ch.kind);
					h_q         <= in_ch.handle;
					k_q         <= in_ch.key;
					rh_q        <= in_ch.ref_handle;
					pos_q       <= in_ch.position;
					rs_status_q <= STAT_OK;
					rs_handle_q <= '0;
					rs_key_q    <= '0;
					rs_found_q  <= 1'b0;
				end
			end
			S_DISPATCH: begin
				idx_q  <= (kind_q == K_INSERT) ? cnt_q : '0;
				sort_q <= (kind_q == K_INSERT) && ordered_q;
				case (kind_q)
					K_INSERT: begin
						if (h_q == '0) begin
							rs_status_q <= STAT_NULL;
						end else if (full) begin
							rs_status_q <= STAT_FULL;
						end
						tgt_q <= ordered_q ? '0 : cnt_q;
					end
					K_BEFORE, K_AFTER: begin
						if (h_q == '0) begin
							rs_status_q <= STAT_NULL;
						end else if (rh_q == '0) begin
							rs_status_q <= STAT_NOTFOUND;
						end
					end
					K_REMOVE, K_CONTAINS: begin
						if (h_q == '0) rs_status_q <= STAT_NULL;
					end
					K_POP: begin
						if (cnt_q == '0) rs_status_q <= STAT_EMPTY;
					end
					K_GET: begin
						if (pos_bad) rs_status_q <= STAT_RANGE;
					end
					default: begin
					end
				endcase
			end
			S_FIND_RD: begin
				if (at_end && kind_q != K_CONTAINS) rs_status_q <= STAT_NOTFOUND;
			end
			S_FIND_CMP: begin
				if (!hit) begin
					idx_q <= idx_inc;
				end else begin
					case (kind_q)
						K_CONTAINS: begin
							rs_found_q <= 1'b1;
						end
						K_REMOVE: begin
							rs_handle_q <= rd_hdl;
							rs_key_q    <= rd_key;
						end
						default: begin
							if (full) begin
								rs_status_q <= STAT_FULL;
							end
							tgt_q <= (kind_q == K_AFTER) ? idx_inc : idx_q;
							idx_q <= cnt_q;
						end
					endcase
				end
			end
			S_UP_CMP: begin
				if (!stop_here) idx_q <= idx_q - 1'b1;
			end
			S_READ_CAP: begin
				rs_handle_q <= rd_hdl;
				rs_key_q    <= rd_key;
				idx_q       <= '0;
			end
			S_DN_MOV: begin
				idx_q <= idx_inc;
			end
			default: begin
			end
		endcase
	end

	// Result register towards out_ch
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			o_valid_q <= 1'b0;
		end else if (deliver) begin
			o_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			o_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (deliver) begin
			o_status_q <= rs_status_q;
			o_handle_q <= rs_handle_q;
			o_key_q    <= rs_key_q;
			o_found_q  <= rs_found_q;
			o_len_q    <= cnt_q;
		end
	end

	assign out_ch.valid      = o_valid_q;
	assign out_ch.status     = o_status_q;
	assign out_ch.out_handle = o_handle_q;
	assign out_ch.out_key    = o_key_q;
	assign out_ch.found      = o_found_q;
	assign out_ch.length     = o_len_q;

	// Checks
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(DEPTH))
		else $error("entry count beyond depth");

	a_no_insert_full: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_UP_CHK) |-> (cnt_q != CNT_W'(DEPTH)))
		else $error("insert sequence entered with queue full");

	a_cnt_step: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q != $past(cnt_q)) |->
			(cnt_q == $past(cnt_q) + 1'b1 || cnt_q == $past(cnt_q) - 1'b1 || cnt_q == '0))
		else $error("entry count moved by more than one");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> (state_q == S_DISPATCH && !in_ch.ready))
		else $error("operation accepted without starting the sequencer");

endmodule

// ===== tb/stable_priority_queue_test.sv =====
`timescale 1ns / 1ps

module stable_priority_queue_test;
	import spq_pkg::*;

	localparam int DEPTH          = 64;
	localparam int KEY_BITS       = 32;
	localparam int HANDLE_BITS    = 16;
	localparam int LEN_BITS       = 7;
	localparam int STUCK_LIMIT    = 20000;
	localparam int HOLDOFF_CYCLES = 3000;
	localparam int TAIL_CYCLES    = 400;
	localparam int PHASE_OPS      = 250;
	localparam int REPORT_CAP     = 200;

	typedef struct packed {
		kind_t                  kind;
		logic [HANDLE_BITS-1:0] handle;
		logic [KEY_BITS-1:0]    key;
		logic [HANDLE_BITS-1:0] ref_handle;
		logic [POS_W-1:0]       position;
	} queue_op_t;

	typedef struct packed {
		logic [STAT_W-1:0]      status;
		logic [HANDLE_BITS-1:0] handle;
		logic [KEY_BITS-1:0]    key;
		logic                   found;
		logic [LEN_BITS-1:0]    len;
	} queue_result_t;

	typedef struct packed {
		logic [DEPTH-1:0][HANDLE_BITS-1:0] hnd;
		logic [DEPTH-1:0][KEY_BITS-1:0]    keys;
		logic [LEN_BITS-1:0]               len;
		logic                              ordered;
	} queue_state_t;

	logic clk       = 1'b0;
	logic arst_n    = 1'b0;
	logic cfg_we    = 1'b0;
	logic cfg_wdata = 1'b0;

	spq_in_if #(.HANDLE_BITS(HANDLE_BITS), .KEY_BITS(KEY_BITS)) in_ch ();
	spq_out_if #(.HANDLE_BITS(HANDLE_BITS), .KEY_BITS(KEY_BITS), .LEN_BITS(LEN_BITS)) out_ch ();

	stable_priority_queue #(
		.DEPTH(DEPTH),
		.KEY_BITS(KEY_BITS),
		.HANDLE_BITS(HANDLE_BITS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.in_ch(in_ch),
		.out_ch(out_ch)
	);

	queue_op_t     pending_ops[$];
	queue_result_t expected_results[$];
	queue_state_t  plan_state;
	queue_state_t  held_state;
	queue_op_t     offered;

	int send_idle_pct  = 0;
	int recv_stall_pct = 0;
	int holdoff_asked  = 0;
	int holdoff_done   = 0;
	int holdoff_left   = 0;
	int stuck_cycles   = 0;
	int results_seen   = 0;
	int errors         = 0;

	int send_pcts [4] = '{0, 57, 0, 23};
	int recv_pcts [4] = '{0, 0, 57, 23};

	// Clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// First position holding this handle, or -1; null never matches
	function automatic int find_first(input queue_state_t s, input logic [HANDLE_BITS-1:0] h);
		int i;
		if (h == '0)
			return -1;
		for (i = 0; i < int'(s.len); i++)
			if (s.hnd[i] == h)
				return i;
		return -1;
	endfunction

	// Shift entries back from p and place the new one there
	function automatic void open_slot(inout queue_state_t s, input int p,
			input logic [HANDLE_BITS-1:0] h, input logic [KEY_BITS-1:0] k);
		int i;
		for (i = int'(s.len); i > p; i--) begin
			s.hnd[i]  = s.hnd[i-1];
			s.keys[i] = s.keys[i-1];
		end
		s.hnd[p]  = h;
		s.keys[p] = k;
		s.len     = s.len + 1'b1;
	endfunction

	// Close the gap left by the entry at p
	function automatic void take_slot(inout queue_state_t s, input int p);
		int i;
		for (i = p; i < int'(s.len) - 1; i++) begin
			s.hnd[i]  = s.hnd[i+1];
			s.keys[i] = s.keys[i+1];
		end
		s.len = s.len - 1'b1;
	endfunction

	// Apply one operation to a queue image and give the result beat it yields
	function automatic queue_result_t step_queue(inout queue_state_t s, input queue_op_t op);
		queue_result_t r;
		int p;
		r = '0;
		case (op.kind)
			K_INSERT: begin
				if (op.handle == '0) begin
					r.status = STAT_NULL;
				end else if (int'(s.len) >= DEPTH) begin
					r.status = STAT_FULL;
				end else begin
					p = int'(s.len);
					if (s.ordered)
						while (p > 0 && op.key < s.keys[p-1])
							p--;
					open_slot(s, p, op.handle, op.key);
				end
			end
			K_BEFORE, K_AFTER: begin
				p = find_first(s, op.ref_handle);
				if (op.handle == '0) begin
					r.status = STAT_NULL;
				end else if (p < 0) begin
					r.status = STAT_NOTFOUND;
				end else if (int'(s.len) >= DEPTH) begin
					r.status = STAT_FULL;
				end else begin
					open_slot(s, (op.kind == K_AFTER) ? p + 1 : p, op.handle, op.key);
				end
			end
			K_REMOVE: begin
				p = find_first(s, op.handle);
				if (op.handle == '0) begin
					r.status = STAT_NULL;
				end else if (p < 0) begin
					r.status = STAT_NOTFOUND;
				end else begin
					r.handle = s.hnd[p];
					r.key    = s.keys[p];
					take_slot(s, p);
				end
			end
			K_POP: begin
				if (s.len == '0) begin
					r.status = STAT_EMPTY;
				end else begin
					r.handle = s.hnd[0];
					r.key    = s.keys[0];
					take_slot(s, 0);
				end
			end
			K_GET: begin
				if (int'(op.position) >= int'(s.len)) begin
					r.status = STAT_RANGE;
				end else begin
					r.handle = s.hnd[op.position];
					r.key    = s.keys[op.position];
				end
			end
			K_CONTAINS: begin
				if (op.handle == '0)
					r.status = STAT_NULL;
				else
					r.found = (find_first(s, op.handle) >= 0);
			end
			default: begin
				s.len = '0;
			end
		endcase
		r.len = s.len;
		return r;
	endfunction

	// Keys: mostly a narrow range so that ties are common
	function automatic logic [KEY_BITS-1:0] random_key();
		int roll;
		roll = $urandom_range(99);
		if (roll < 5)
			return '0;
		if (roll < 10)
			return '1;
		if (roll < 30)
			return KEY_BITS'($urandom);
		return KEY_BITS'($urandom_range(20));
	endfunction

	// Handles: a small pool, held entries, and now and then null or wide values
	function automatic logic [HANDLE_BITS-1:0] pick_handle(input queue_state_t s);
		int roll;
		int idx;
		roll = $urandom_range(99);
		if (roll < 4)
			return '0;
		if (roll < 7)
			return HANDLE_BITS'($urandom);
		if (roll < 9)
			return '1;
		if (roll < 50 && s.len != '0) begin
			idx = $urandom_range(int'(s.len) - 1);
			return s.hnd[idx];
		end
		return HANDLE_BITS'($urandom_range(48, 1));
	endfunction

	// One random operation, steered so the queue length drifts towards target
	function automatic queue_op_t random_op(input queue_state_t s, input int target);
		queue_op_t op;
		int roll;
		int held;
		int w_ins;
		int w_rem;
		int w_pop;
		int idx;
		held          = int'(s.len);
		op.kind       = kind_t'($urandom_range(7));
		op.handle     = HANDLE_BITS'($urandom);
		op.key        = KEY_BITS'($urandom);
		op.ref_handle = HANDLE_BITS'($urandom);
		op.position   = POS_W'($urandom);
		// Plain noise: every field random
		if ($urandom_range(99) < 8)
			return op;
		w_ins = (held < target) ? 40 : 8;
		w_rem = (held < target) ? 8 : 24;
		w_pop = (held < target) ? 4 : 14;
		roll  = $urandom_range(w_ins + w_rem + w_pop + 38);
		if (roll < w_ins)
			op.kind = K_INSERT;
		else if (roll < w_ins + 8)
			op.kind = K_BEFORE;
		else if (roll < w_ins + 16)
			op.kind = K_AFTER;
		else if (roll < w_ins + 16 + w_rem)
			op.kind = K_REMOVE;
		else if (roll < w_ins + 16 + w_rem + w_pop)
			op.kind = K_POP;
		else if (roll < w_ins + 28 + w_rem + w_pop)
			op.kind = K_GET;
		else if (roll < w_ins + 38 + w_rem + w_pop)
			op.kind = K_CONTAINS;
		else
			op.kind = K_CLEAR;
		op.handle = pick_handle(s);
		op.key    = random_key();
		if (held > 0 && $urandom_range(99) < 70) begin
			idx           = $urandom_range(held - 1);
			op.ref_handle = s.hnd[idx];
		end else begin
			op.ref_handle = pick_handle(s);
		end
		if (held > 0 && $urandom_range(99) < 85)
			op.position = POS_W'($urandom_range(held - 1));
		return op;
	endfunction

	task automatic report_mismatch(input string what, input queue_result_t got,
			input queue_result_t want);
		errors++;
		if (errors <= REPORT_CAP)
			$display("result %0d %s: got st=%0d h=%h k=%h f=%0d len=%0d, want st=%0d h=%h k=%h f=%0d len=%0d",
				results_seen, what, got.status, got.handle, got.key, got.found, got.len,
				want.status, want.handle, want.key, want.found, want.len);
	endtask

	// Queue one operation and advance the planning image with it
	task automatic plan_op(input queue_op_t op);
		void'(step_queue(plan_state, op));
		pending_ops.push_back(op);
	endtask

	task automatic plan_fields(input kind_t kind, input logic [HANDLE_BITS-1:0] h,
			input logic [KEY_BITS-1:0] k, input logic [HANDLE_BITS-1:0] rh,
			input logic [POS_W-1:0] pos);
		queue_op_t op;
		op.kind       = kind;
		op.handle     = h;
		op.key        = k;
		op.ref_handle = rh;
		op.position   = pos;
		plan_op(op);
	endtask

	// Hold until every queued operation has been taken and answered
	task automatic wait_drained();
		do
			@(negedge clk);
		while (pending_ops.size() != 0 || in_ch.valid || expected_results.size() != 0);
	endtask

	task automatic write_mode(input logic mode);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= mode;
		@(posedge clk);
		cfg_we <= 1'b0;
		plan_state.ordered = mode;
		held_state.ordered = mode;
		@(negedge clk);
	endtask

	// Driver: offer the next pending operation, predict on each accepted beat
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_ch.valid && in_ch.ready)
				expected_results.push_back(step_queue(held_state, offered));
			if (!in_ch.valid || in_ch.ready) begin
				if (pending_ops.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					offered = pending_ops.pop_front();
					in_ch.valid      <= 1'b1;
					in_ch.kind       <= offered.kind;
					in_ch.handle     <= offered.handle;
					in_ch.key        <= offered.key;
					in_ch.ref_handle <= offered.ref_handle;
					in_ch.position   <= offered.position;
				end else begin
					in_ch.valid <= 1'b0;
				end
			end
		end
	end

	// Monitor: check each result beat against the oldest prediction
	always @(posedge clk) begin
		queue_result_t got;
		queue_result_t want;
		if (arst_n) begin
			if (out_ch.valid && out_ch.ready) begin
				got.status = out_ch.status;
				got.handle = out_ch.out_handle;
				got.key    = out_ch.out_key;
				got.found  = out_ch.found;
				got.len    = out_ch.length;
				if (expected_results.size() == 0) begin
					report_mismatch("arrived with nothing expected", got, '0);
				end else begin
					want = expected_results.pop_front();
					if (got !== want)
						report_mismatch("mismatch", got, want);
				end
				results_seen++;
			end
			out_ch.ready <= (holdoff_left == 0) && ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// Long receiver hold-off, served on request
	always @(posedge clk) begin
		if (holdoff_left != 0) begin
			holdoff_left <= holdoff_left - 1;
		end else if (holdoff_done != holdoff_asked) begin
			holdoff_left <= HOLDOFF_CYCLES;
			holdoff_done <= holdoff_done + 1;
		end
	end

	// Watchdog: end the run when no beat moves for too long
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
				stuck_cycles <= 0;
			end else if (stuck_cycles >= STUCK_LIMIT) begin
				$display("*** FAILED ***");
				$finish;
			end else begin
				stuck_cycles <= stuck_cycles + 1;
			end
		end
	end

	// Stimulus sequence
	initial begin
		int ph;
		int n;
		int target;
		in_ch.valid      = 1'b0;
		in_ch.kind       = K_INSERT;
		in_ch.handle     = '0;
		in_ch.key        = '0;
		in_ch.ref_handle = '0;
		in_ch.position   = '0;
		out_ch.ready     = 1'b0;
		plan_state       = '0;
		held_state       = '0;
		offered          = '0;

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed, tail append: empty cases, null handles, missing refs, duplicates
		write_mode(1'b0);
		plan_fields(K_POP, 16'd3, 32'd0, 16'd0, 6'd0);
		plan_fields(K_GET, 16'd0, 32'd0, 16'd0, 6'd0);
		plan_fields(K_BEFORE, 16'd4, 32'd1, 16'd5, 6'd0);
		plan_fields(K_INSERT, 16'd0, 32'd7, 16'd0, 6'd0);
		plan_fields(K_REMOVE, 16'd0, 32'd0, 16'd0, 6'd0);
		plan_fields(K_CONTAINS, 16'd0, 32'd0, 16'd0, 6'd0);
		plan_fields(K_BEFORE, 16'd0, 32'd0, 16'hFFFF, 6'd0);
		plan_fields(K_AFTER, 16'd7, 32'd0, 16'd0, 6'd0);
		plan_fields(K_INSERT, 16'hFFFF, 32'hFFFF_FFFF, 16'd0, 6'd63);
		plan_fields(K_INSERT, 16'd1, 32'd0, 16'hFFFF, 6'd0);
		plan_fields(K_INSERT, 16'd1, 32'd5, 16'd0, 6'd0);
		plan_fields(K_BEFORE, 16'd2, 32'd3, 16'd1, 6'd0);
		plan_fields(K_AFTER, 16'd3, 32'd9, 16'hFFFF, 6'd0);
		plan_fields(K_CONTAINS, 16'd1, 32'd0, 16'd0, 6'd0);
		plan_fields(K_CONTAINS, 16'd4, 32'd0, 16'd0, 6'd0);
		plan_fields(K_GET, 16'd0, 32'd0, 16'd0, 6'd63);
		plan_fields(K_GET, 16'd0, 32'd0, 16'd0, 6'd2);
		plan_fields(K_REMOVE, 16'd1, 32'd0, 16'd0, 6'd0);
		plan_fields(K_REMOVE, 16'd9, 32'd0, 16'd0, 6'd0);
		plan_fields(K_POP, 16'd0, 32'd0, 16'd0, 6'd0);
		plan_fields(K_CLEAR, 16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF, 6'd63);
		wait_drained();

		// Directed, sorted: ties keep arrival order, zero key to the front
		write_mode(1'b1);
		plan_fields(K_INSERT, 16'd10, 32'd5, 16'd0, 6'd0);
		plan_fields(K_INSERT, 16'd11, 32'd5, 16'd0, 6'd0);
		plan_fields(K_INSERT, 16'd12, 32'd0, 16'd0, 6'd0);
		plan_fields(K_INSERT, 16'd13, 32'hFFFF_FFFF, 16'd0, 6'd0);
		plan_fields(K_INSERT, 16'd14, 32'd5, 16'd0, 6'd0);
		plan_fields(K_GET, 16'd0, 32'd0, 16'd0, 6'd3);
		plan_fields(K_BEFORE, 16'd15, 32'd1, 16'd13, 6'd0);
		plan_fields(K_POP, 16'd0, 32'd0, 16'd0, 6'd0);
		wait_drained();

		// Fill past capacity while the receiver holds off
		holdoff_asked = holdoff_asked + 1;
		for (n = 0; n < DEPTH + 8; n++)
			plan_fields(K_INSERT, HANDLE_BITS'($urandom_range(60, 1)),
				KEY_BITS'($urandom_range(30)), HANDLE_BITS'($urandom), POS_W'($urandom));
		wait_drained();

		// At capacity: check ordering of the error checks, then empty out
		plan_fields(K_INSERT, 16'd0, 32'd1, 16'd0, 6'd0);
		plan_fields(K_BEFORE, 16'd5, 32'd1, 16'hBEEF, 6'd0);
		plan_fields(K_AFTER, 16'd6, 32'd1, plan_state.hnd[DEPTH-1], 6'd0);
		plan_fields(K_GET, 16'd0, 32'd0, 16'd0, 6'd63);
		plan_fields(K_REMOVE, plan_state.hnd[DEPTH-1], 32'd0, 16'd0, 6'd0);
		plan_fields(K_POP, 16'd0, 32'd0, 16'd0, 6'd0);
		plan_fields(K_CLEAR, 16'd0, 32'd0, 16'd0, 6'd0);
		wait_drained();

		// Random phases over both modes and every idling pattern
		for (ph = 0; ph < 8; ph++) begin
			write_mode(ph[0]);
			send_idle_pct  = send_pcts[ph / 2];
			recv_stall_pct = recv_pcts[ph / 2];
			target         = 8;
			for (n = 0; n < PHASE_OPS; n++) begin
				if (n % 50 == 0)
					target = ($urandom_range(9) == 0) ? DEPTH : $urandom_range(24, 2);
				plan_op(random_op(plan_state, target));
			end
			wait_drained();
		end

		repeat (TAIL_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
